/* design/hlt_pkg.sv */
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and constants for the handle lifetime tracker.
// ----------------------------------------------------------------------------
package hlt_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam int KIND_W    = 2;
    localparam int HANDLE_W  = 64;
    localparam int TYPE_W    = 32;
    localparam int FAIL_W    = 2;
    localparam int CNT_OUT_W = 7;

    // input stream: handle, object_type in tdata; kind in tuser
    localparam int S_TDATA_W = HANDLE_W + TYPE_W;
    localparam int S_TUSER_W = KIND_W;

    // output stream: ok, last_failure, reconciled, used_count, destroyed_count
    localparam int M_FIELD_W = 1 + FAIL_W + 1 + CNT_OUT_W + CNT_OUT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

    localparam logic [FAIL_W-1:0] FAIL_NONE            = 2'd0;
    localparam logic [FAIL_W-1:0] FAIL_DOUBLE_CREATE   = 2'd1;
    localparam logic [FAIL_W-1:0] FAIL_KIND_MISMATCH   = 2'd2;
    localparam logic [FAIL_W-1:0] FAIL_DESTROY_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the accepted input transaction
        logic issue;    // read the next table entry
        logic commit;   // apply the operation and load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic skip;        // no table scan needed
        logic issue_done;  // all used entries have been read
        logic cmp_pend;    // a read is still in the compare stage
        logic found;       // live match found
        logic out_free;    // result register can take a new result
    } t_status;

endpackage

/* design/hlt_ctrl.sv */
// ----------------------------------------------------------------------------
// hlt_ctrl
// Sequencer: accept, scan the table, commit the operation.
// ----------------------------------------------------------------------------
module hlt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  hlt_pkg::t_status i_status,
    output hlt_pkg::t_cmd    o_cmd
);
    import hlt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = !i_status.skip && !i_status.issue_done && !i_status.found;
                if (i_status.skip || i_status.found ||
                    (i_status.issue_done && !i_status.cmp_pend)) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/hlt_dpath.sv */
// ----------------------------------------------------------------------------
// hlt_dpath
// Entry table, scan compare stage, counters and result register.
// ----------------------------------------------------------------------------
module hlt_dpath #(
    parameter int ENTRIES = hlt_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hlt_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [hlt_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  hlt_pkg::t_cmd                 i_cmd,
    output hlt_pkg::t_status              o_status,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [hlt_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import hlt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // table
    logic [HANDLE_W-1:0] r_mem_handle [ENTRIES];
    logic [TYPE_W-1:0]   r_mem_type   [ENTRIES];
    logic                r_mem_live   [ENTRIES];

    // latched transaction
    logic [KIND_W-1:0]   r_kind;
    logic [HANDLE_W-1:0] r_handle;
    logic [TYPE_W-1:0]   r_type;

    // scan
    logic [CNT_W-1:0]    r_issue_idx;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic [HANDLE_W-1:0] r_rd_handle;
    logic [TYPE_W-1:0]   r_rd_type;
    logic                r_rd_live;
    logic                r_found;
    logic [IDX_W-1:0]    r_found_idx;
    logic [TYPE_W-1:0]   r_found_type;

    // persistent state
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_destr;
    logic [FAIL_W-1:0]   r_fail;

    // result
    logic                r_out_vld;
    logic [M_TDATA_W-1:0] r_out_data;

    logic                full;
    logic                skip;
    logic                hit;
    logic [CNT_W-1:0]    n_used;
    logic [CNT_W-1:0]    n_destr;
    logic [FAIL_W-1:0]   n_fail;
    logic                n_ok;
    logic                n_rec;
    logic                wr_ent;
    logic                wr_live;
    logic [IDX_W-1:0]    live_addr;
    logic                live_val;

    assign full = (r_used == CNT_W'(ENTRIES));
    assign skip = (r_kind != KIND_CREATE && r_kind != KIND_DESTROY && r_kind != KIND_QUERY)
               || (r_handle == '0) || (r_kind == KIND_CREATE && full);
    assign hit  = r_cmp_vld && r_rd_live && (r_rd_handle == r_handle);

    assign o_status.skip       = skip;
    assign o_status.issue_done = (r_issue_idx == r_used);
    assign o_status.cmp_pend   = r_cmp_vld;
    assign o_status.found      = r_found;
    assign o_status.out_free   = !r_out_vld || i_m_tready;

    // table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_ent) begin
            r_mem_handle[r_used[IDX_W-1:0]] <= r_handle;
            r_mem_type[r_used[IDX_W-1:0]]   <= r_type;
        end
        if (i_cmd.issue) begin
            r_rd_handle <= r_mem_handle[r_issue_idx[IDX_W-1:0]];
            r_rd_type   <= r_mem_type[r_issue_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_live) begin
            r_mem_live[live_addr] <= live_val;
        end
        if (i_cmd.issue) begin
            r_rd_live <= r_mem_live[r_issue_idx[IDX_W-1:0]];
        end
    end

    // transaction latch and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_s_tuser;
            r_handle <= i_s_tdata[HANDLE_W-1:0];
            r_type   <= i_s_tdata[HANDLE_W +: TYPE_W];
        end
        if (i_cmd.issue) begin
            r_cmp_idx <= r_issue_idx[IDX_W-1:0];
        end
        if (hit && !r_found) begin
            r_found_idx  <= r_cmp_idx;
            r_found_type <= r_rd_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_idx <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
        end else if (i_cmd.load) begin
            r_issue_idx <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.issue) begin
                r_issue_idx <= r_issue_idx + CNT_W'(1);
            end
            if (hit) begin
                r_found <= 1'b1;
            end
        end
    end

    // operation outcome
    always_comb begin
        n_used    = r_used;
        n_destr   = r_destr;
        n_fail    = r_fail;
        n_ok      = 1'b0;
        wr_ent    = 1'b0;
        wr_live   = 1'b0;
        live_addr = r_used[IDX_W-1:0];
        live_val  = 1'b1;
        unique case (r_kind)
            KIND_CREATE: begin
                if (!skip) begin
                    if (r_found) begin
                        n_fail = FAIL_DOUBLE_CREATE;
                    end else begin
                        wr_ent  = 1'b1;
                        wr_live = 1'b1;
                        n_used  = r_used + CNT_W'(1);
                        n_ok    = 1'b1;
                    end
                end
            end
            KIND_DESTROY: begin
                if (r_handle != '0) begin
                    if (!r_found) begin
                        n_fail = FAIL_DESTROY_UNKNOWN;
                    end else if (r_found_type != r_type) begin
                        n_fail = FAIL_KIND_MISMATCH;
                    end else begin
                        wr_live   = 1'b1;
                        live_addr = r_found_idx;
                        live_val  = 1'b0;
                        n_destr   = r_destr + CNT_W'(1);
                        n_ok      = 1'b1;
                    end
                end
            end
            KIND_QUERY: begin
                n_ok = r_found;
            end
            default: begin
            end
        endcase
        n_rec = (n_fail == FAIL_NONE) && (n_used == n_destr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_destr   <= '0;
            r_fail    <= FAIL_NONE;
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_used    <= n_used;
            r_destr   <= n_destr;
            r_fail    <= n_fail;
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {(M_TDATA_W - M_FIELD_W)'(0), CNT_OUT_W'(n_destr),
                           CNT_OUT_W'(n_used), n_rec, n_fail, n_ok};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(ENTRIES))
        else $error("used count beyond table size");

    a_destr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_destr <= r_used)
        else $error("more destroys than creates");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_vld || i_m_tready))
        else $error("result overwritten before it was taken");

    a_found_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (CNT_W'(r_found_idx) < r_used))
        else $error("match outside used entries");

endmodule

/* design/handle_lifetime_tracker.sv */
// ----------------------------------------------------------------------------
// handle_lifetime_tracker
// Append-only handle table with create, destroy and query operations.
// ----------------------------------------------------------------------------
// One operation is processed at a time. An accepted transaction scans the
// used entries in order, one table read per cycle, and stops at the first
// live match. A transaction with handle zero, an unused kind, or a create
// on a full table skips the scan; for any other transaction the scan of
// the used entries through the single table read port sets its duration.
// The result sits in an output register, so the next transaction is taken
// while a result waits; a commit stalls only while that register is held.
// ----------------------------------------------------------------------------
module handle_lifetime_tracker #(
    parameter int ENTRIES = hlt_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [63:0] handle, [95:64] object_type
    input  logic [hlt_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] kind
    input  logic [hlt_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [0] ok, [2:1] last_failure, [3] reconciled, [10:4] used_count,
    // [17:11] destroyed_count, [23:18] zero
    output logic [hlt_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import hlt_pkg::*;

    t_cmd    cmd;
    t_status status;

    hlt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    hlt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule
